// ===== rtl/yaw_lead_with_spin_detector_core_defines.svh =====
// Assertion helpers used by the core RTL file to check its own logic.
// Both expect clk and rst_n in scope.
`ifndef YAW_LEAD_WITH_SPIN_DETECTOR_CORE_DEFINES_SVH
`define YAW_LEAD_WITH_SPIN_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define YLD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define YLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/yld_pkg.sv =====
package yld_pkg;

  // field widths
  localparam int X_W      = 15;
  localparam int DIST_W   = 16;
  localparam int GYRO_W   = 24;
  localparam int OUT_W    = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // shared multiplier operand widths
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // register reset values
  localparam logic [23:0] RATE_GAIN_RST    = 24'd292456;
  localparam logic [15:0] LEAD_SLOPE_RST   = 16'd2969;
  localparam logic [23:0] LEAD_OFFSET_RST  = 24'd157286;
  localparam logic [16:0] REJECT_LIMIT_RST = 17'd76800;
  localparam logic [16:0] CLAMP_LIMIT_RST  = 17'd10240;
  localparam logic [31:0] SPIN_THRESH_RST  = 32'd1280000;
  localparam logic [7:0]  SPIN_LIMIT_RST   = 8'd3;
  localparam logic [15:0] WINDOW_RST       = 16'd160;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_GAIN    = 3'd0,
    CFG_LEAD_SLOPE   = 3'd1,
    CFG_LEAD_OFFSET  = 3'd2,
    CFG_REJECT_LIMIT = 3'd3,
    CFG_CLAMP_LIMIT  = 3'd4,
    CFG_SPIN_THRESH  = 3'd5,
    CFG_SPIN_LIMIT   = 3'd6,
    CFG_WINDOW       = 3'd7
  } cfg_idx_t;

  // spin detector settings
  typedef struct packed {
    logic [31:0] thresh;
    logic [15:0] window;
    logic [7:0]  count_limit;
  } spin_cfg_t;

endpackage

// ===== rtl/yld_ifs.sv =====
interface yld_in_if import yld_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [X_W-1:0]           target_x;
  logic [DIST_W-1:0]        target_distance;
  logic signed [GYRO_W-1:0] gyro_yaw_rate;

  modport source (output valid, target_x, target_distance, gyro_yaw_rate, input ready);
  modport sink   (input valid, target_x, target_distance, gyro_yaw_rate, output ready);
endinterface

interface yld_out_if import yld_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] yaw_target;
  logic signed [OUT_W-1:0] relative_speed;
  logic                    spin_detected;

  modport source (output valid, yaw_target, relative_speed, spin_detected, input ready);
  modport sink   (input valid, yaw_target, relative_speed, spin_detected, output ready);
endinterface

interface yld_cfg_if import yld_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/yaw_lead_with_spin_detector_core.sv =====
// The result is loaded into the output register in S_FINAL; the next input is taken back in S_IDLE.
// Each frame takes five passes through the one shared
//   18x25 multiplier plus the rounding, limiting and saturation steps around it.
// A waiting result stalls the final step; a new input is not taken until the result is loaded.
// Reset (rst_n low, synchronous): registers to defaults, spin state and previous x cleared.
`include "yaw_lead_with_spin_detector_core_defines.svh"

module yaw_lead_with_spin_detector_core import yld_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  yld_in_if.sink   in_ch,
  yld_out_if.source out_ch,
  yld_cfg_if.sink  cfg_ch
);

  // Sequencer: each MUL-using state drives the shared multiplier, the
  // following state consumes its registered product.
  typedef enum logic [3:0] {
    S_IDLE,   // wait for a frame
    S_RATE,   // mul d * rate_gain
    S_SPIN,   // round rate; mul d * distance
    S_FAC,    // rel = rate - gyro; spin update; mul distance * lead_slope
    S_LIMIT,  // factor = product + offset; reject/clamp/spin cancel
    S_LO,     // mul rel * factor[16:0]
    S_HI,     // keep low part; mul rel * factor[32:17]
    S_SUM,    // full = lo + hi << 17
    S_LEAD,   // lead = round(full / 2^20)
    S_FINAL   // yaw = x + lead, saturate, load output register
  } state_t;

  state_t state_r;

  // configuration registers
  logic [23:0] gain_r, offset_r;
  logic [15:0] slope_r, window_r;
  logic [16:0] reject_r, clamp_r;
  logic [31:0] thr_r;
  logic [7:0]  cnt_lim_r;

  // frame datapath
  logic [X_W-1:0]           x_r, prev_x_r;
  logic [DIST_W-1:0]        dist_r;
  logic signed [GYRO_W-1:0] gyro_r;
  logic signed [15:0]       d_r;
  logic signed [28:0]       rate_r;
  logic signed [29:0]       rel_raw_r;
  logic signed [17:0]       rel_lim_r;
  logic [32:0]              factor_r;
  logic signed [34:0]       acc_r;
  logic signed [51:0]       full_r;
  logic signed [31:0]       lead_r;
  logic                     spin_r;

  // output register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] yaw_out_r, rel_out_r;
  logic                    spin_out_r;

  // handshakes
  logic in_ready_w, in_fire, out_fire, out_free, out_load;

  // shared multiplier
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  // spin detector
  spin_cfg_t spin_cfg;
  logic      spin_step, spin_hit;

  // combinational helpers
  logic [MUL_P_W-1:0] rnd12;
  logic [29:0]        mag;
  logic signed [17:0] rel_lim_w;
  logic [51:0]        rnd20;
  logic signed [32:0] yaw_sum;
  logic signed [17:0] yaw_sat;

  assign in_ready_w = (state_r == S_IDLE);
  assign in_fire    = in_ch.valid & in_ready_w;
  assign out_fire   = out_valid_r & out_ch.ready;
  assign out_free   = ~out_valid_r | out_ch.ready;
  assign out_load   = (state_r == S_FINAL) & out_free;

  assign in_ch.ready  = in_ready_w;
  assign cfg_ch.ready = 1'b1;  // writes are expected only while idle

  assign out_ch.valid          = out_valid_r;
  assign out_ch.yaw_target     = yaw_out_r;
  assign out_ch.relative_speed = rel_out_r;
  assign out_ch.spin_detected  = spin_out_r;

  // multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_RATE: begin
        mul_a = {{2{d_r[15]}}, d_r};
        mul_b = {1'b0, gain_r};
      end
      S_SPIN: begin
        mul_a = {{2{d_r[15]}}, d_r};
        mul_b = {9'd0, dist_r};
      end
      S_FAC: begin
        mul_a = {2'b00, dist_r};
        mul_b = {9'd0, slope_r};
      end
      S_LO: begin
        mul_a = rel_lim_r;
        mul_b = {8'd0, factor_r[16:0]};
      end
      S_HI: begin
        mul_a = rel_lim_r;
        mul_b = {9'd0, factor_r[32:17]};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  yld_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign spin_cfg  = '{thresh: thr_r, window: window_r, count_limit: cnt_lim_r};
  assign spin_step = (state_r == S_FAC);  // product holds d * distance here

  yld_spin u_spin (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (spin_step),
    .v        (prod[33:0]),
    .cfg      (spin_cfg),
    .spin_hit (spin_hit)
  );

  always_comb begin
    // round to nearest, ties away from zero: (v + half - neg) >>> s
    rnd12 = prod + {{(MUL_P_W-12){1'b0}}, 12'h800} - {{(MUL_P_W-1){1'b0}}, prod[MUL_P_W-1]};

    // reject first, then clamp, then spin cancel
    mag = rel_raw_r[29] ? (~rel_raw_r + 30'd1) : rel_raw_r;
    if (mag > {13'd0, reject_r}) begin
      rel_lim_w = '0;
    end else if (mag > {13'd0, clamp_r}) begin
      rel_lim_w = rel_raw_r[29] ? (~{1'b0, clamp_r} + 18'd1) : {1'b0, clamp_r};
    end else begin
      rel_lim_w = rel_raw_r[17:0];
    end
    if (spin_hit) begin
      rel_lim_w = '0;
    end

    rnd20 = full_r + {32'd0, 20'h80000} - {51'd0, full_r[51]};

    yaw_sum = {18'd0, x_r} + {lead_r[31], lead_r};
    if (yaw_sum > 33'sd131071) begin
      yaw_sat = 18'sh1FFFF;
    end else if (yaw_sum < -33'sd131072) begin
      yaw_sat = 18'sh20000;
    end else begin
      yaw_sat = yaw_sum[17:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= RATE_GAIN_RST;
      slope_r   <= LEAD_SLOPE_RST;
      offset_r  <= LEAD_OFFSET_RST;
      reject_r  <= REJECT_LIMIT_RST;
      clamp_r   <= CLAMP_LIMIT_RST;
      thr_r     <= SPIN_THRESH_RST;
      cnt_lim_r <= SPIN_LIMIT_RST;
      window_r  <= WINDOW_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_RATE_GAIN:    gain_r    <= cfg_ch.data[23:0];
        CFG_LEAD_SLOPE:   slope_r   <= cfg_ch.data[15:0];
        CFG_LEAD_OFFSET:  offset_r  <= cfg_ch.data[23:0];
        CFG_REJECT_LIMIT: reject_r  <= cfg_ch.data[16:0];
        CFG_CLAMP_LIMIT:  clamp_r   <= cfg_ch.data[16:0];
        CFG_SPIN_THRESH:  thr_r     <= cfg_ch.data;
        CFG_SPIN_LIMIT:   cnt_lim_r <= cfg_ch.data[7:0];
        CFG_WINDOW:       window_r  <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_x_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a load wins over the transfer of the previous result
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            x_r      <= in_ch.target_x;
            dist_r   <= in_ch.target_distance;
            gyro_r   <= in_ch.gyro_yaw_rate;
            d_r      <= {1'b0, in_ch.target_x} - {1'b0, prev_x_r};
            prev_x_r <= in_ch.target_x;
            state_r  <= S_RATE;
          end
        end
        S_RATE: begin
          state_r <= S_SPIN;
        end
        S_SPIN: begin
          rate_r  <= rnd12[40:12];
          state_r <= S_FAC;
        end
        S_FAC: begin
          rel_raw_r <= {rate_r[28], rate_r} - {{6{gyro_r[23]}}, gyro_r};
          state_r   <= S_LIMIT;
        end
        S_LIMIT: begin
          factor_r  <= {1'b0, prod[31:0]} + {9'd0, offset_r};
          rel_lim_r <= rel_lim_w;
          spin_r    <= spin_hit;
          state_r   <= S_LO;
        end
        S_LO: begin
          state_r <= S_HI;
        end
        S_HI: begin
          acc_r   <= prod[34:0];
          state_r <= S_SUM;
        end
        S_SUM: begin
          full_r  <= {{17{acc_r[34]}}, acc_r} + {prod[34:0], 17'd0};
          state_r <= S_LEAD;
        end
        S_LEAD: begin
          lead_r  <= rnd20[51:20];
          state_r <= S_FINAL;
        end
        S_FINAL: begin
          if (out_free) begin
            yaw_out_r  <= yaw_sat;
            rel_out_r  <= rel_lim_r;
            spin_out_r <= spin_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `YLD_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_w, "input taken while busy")
  `YLD_ASSERT_SAME(a_cancel_zeroes_rel, (state_r == S_LO) && spin_r, rel_lim_r == 18'sd0, "spin cancel lost")
  `YLD_ASSERT_SAME(a_out_spin_zero, out_valid_r && spin_out_r, rel_out_r == 18'sd0, "spin result with speed")

endmodule

// ===== rtl/yld_mul.sv =====
// Shared signed multiplier, product registered.
module yld_mul import yld_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  logic signed [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/yld_spin.sv =====
// Forward/reverse spin detectors with windowed count latching.
module yld_spin import yld_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic signed [33:0] v,
  input  spin_cfg_t          cfg,
  output logic               spin_hit
);

  logic        fwd_armed_r, rev_armed_r;
  logic [15:0] fwd_cnt_r, rev_cnt_r, fwd_lat_r, rev_lat_r, frame_idx_r;

  logic signed [33:0] thr_s;
  logic        v_lt, v_gt, v_le0;
  logic        fa_set, ra_set, fwd_fire, rev_fire;
  logic [15:0] fwd_inc, rev_inc, win;
  logic [16:0] idx_p1;

  always_comb begin
    thr_s    = $signed({2'b00, cfg.thresh});
    v_lt     = v < -thr_s;
    v_gt     = v > thr_s;
    v_le0    = v[33] | (v == 34'sd0);
    ra_set   = rev_armed_r | v_lt;
    rev_fire = ra_set & ~v[33];
    fa_set   = fwd_armed_r | v_gt;
    fwd_fire = fa_set & v_le0;
    fwd_inc  = fwd_cnt_r + {15'd0, fwd_fire};
    rev_inc  = rev_cnt_r + {15'd0, rev_fire};
    win      = (cfg.window == 16'd0) ? 16'd1 : cfg.window;
    idx_p1   = {1'b0, frame_idx_r} + 17'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_armed_r <= 1'b0;
      rev_armed_r <= 1'b0;
      fwd_cnt_r   <= '0;
      rev_cnt_r   <= '0;
      fwd_lat_r   <= '0;
      rev_lat_r   <= '0;
      frame_idx_r <= '0;
    end else if (step) begin
      fwd_armed_r <= fa_set & ~fwd_fire;
      rev_armed_r <= ra_set & ~rev_fire;
      if (frame_idx_r == 16'd0) begin
        fwd_lat_r <= fwd_inc;
        rev_lat_r <= rev_inc;
        fwd_cnt_r <= '0;
        rev_cnt_r <= '0;
      end else begin
        fwd_cnt_r <= fwd_inc;
        rev_cnt_r <= rev_inc;
      end
      frame_idx_r <= (idx_p1 >= {1'b0, win}) ? 16'd0 : idx_p1[15:0];
    end
  end

  assign spin_hit = (fwd_lat_r >= {8'd0, cfg.count_limit}) ||
                    (rev_lat_r >= {8'd0, cfg.count_limit});

endmodule
